[rtl/core/clsr_pkg.sv]
package clsr_pkg;

	localparam int VAL_W  = 31;
	localparam int MUL_W  = 16;
	localparam int FOLD_W = 8;
	localparam int PROD_W = VAL_W + MUL_W;

	localparam int SHUFFLE_ENTRIES_DEF = 32;
	localparam int WARMUP_STEPS        = 8;

	// moduli are 2^31 - fold
	localparam logic [31:0]       MOD_ONE  = 32'd2147483563;
	localparam logic [31:0]       MOD_TWO  = 32'd2147483399;
	localparam logic [MUL_W-1:0]  MUL_ONE  = 16'd40014;
	localparam logic [MUL_W-1:0]  MUL_TWO  = 16'd40692;
	localparam logic [FOLD_W-1:0] FOLD_ONE = 8'd85;
	localparam logic [FOLD_W-1:0] FOLD_TWO = 8'd249;

	localparam logic [VAL_W-1:0] FIRST_RESET  = 31'd1;
	localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;

	typedef enum logic {
		GEN_ONE,
		GEN_TWO
	} gen_t;

	typedef struct packed {
		logic load;
		gen_t sel;
	} mm_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_RED,
		ST_MUL_ONE,
		ST_RED_ONE,
		ST_RED_TWO,
		ST_READ,
		ST_WRITE
	} state_t;

endpackage

[rtl/core/clsr_modmul.sv]
module clsr_modmul (
	input  logic                            clk,
	input  clsr_pkg::mm_req_t               req,
	input  logic [clsr_pkg::VAL_W-1:0]      z,
	output logic [clsr_pkg::VAL_W-1:0]      res
);

	logic [clsr_pkg::MUL_W-1:0]  mul;
	logic [clsr_pkg::PROD_W-1:0] p_s1;
	clsr_pkg::gen_t              sel_s1;

	logic [clsr_pkg::MUL_W-1:0]  hi;
	logic [clsr_pkg::VAL_W-1:0]  lo;
	logic [clsr_pkg::FOLD_W-1:0] fold;
	logic [31:0]                 modulus;
	logic [31:0]                 sum;
	logic [31:0]                 sum_sub;

	assign mul = (req.sel == clsr_pkg::GEN_ONE) ? clsr_pkg::MUL_ONE : clsr_pkg::MUL_TWO;

	always_ff @(posedge clk) begin
		if (req.load) begin
			p_s1   <= clsr_pkg::PROD_W'(mul) * clsr_pkg::PROD_W'(z);
			sel_s1 <= req.sel;
		end
	end

	// a*z = hi*2^31 + lo == hi*fold + lo (mod 2^31 - fold); one correction
	assign hi      = p_s1[clsr_pkg::PROD_W-1:clsr_pkg::VAL_W];
	assign lo      = p_s1[clsr_pkg::VAL_W-1:0];
	assign fold    = (sel_s1 == clsr_pkg::GEN_ONE) ? clsr_pkg::FOLD_ONE : clsr_pkg::FOLD_TWO;
	assign modulus = (sel_s1 == clsr_pkg::GEN_ONE) ? clsr_pkg::MOD_ONE : clsr_pkg::MOD_TWO;
	assign sum     = (32'(hi) * 32'(fold)) + 32'(lo);
	assign sum_sub = sum - modulus;
	assign res     = (sum >= modulus) ? sum_sub[clsr_pkg::VAL_W-1:0]
	                                  : sum[clsr_pkg::VAL_W-1:0];

endmodule

[rtl/core/clsr_table.sv]
module clsr_table #(
	parameter int ENTRIES = clsr_pkg::SHUFFLE_ENTRIES_DEF,
	parameter int IW      = $clog2(ENTRIES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [IW-1:0]              rd_addr,
	input  logic                       wr_en,
	input  logic [IW-1:0]              wr_addr,
	input  logic [clsr_pkg::VAL_W-1:0] wr_data,
	output logic [clsr_pkg::VAL_W-1:0] rd_data
);

	logic [clsr_pkg::VAL_W-1:0] mem [ENTRIES];
	logic [ENTRIES-1:0]         vld_q;
	logic                       rd_vld_q;
	logic [clsr_pkg::VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

[rtl/core/combined_lcg_shuffle_rng_unit.sv]
// Combined two-generator random number unit with a shuffle table. Each item
// is a draw (action = 0) or a reseed followed by a draw (action = 1) and gives
// exactly one value in 1 .. 2147483562; divide by 2147483563 for a fraction.
// A seed of zero is taken as one. One item is worked at a time: in_stall is
// high from acceptance until the result is placed in the output register,
// which then waits for the consumer while the next item may already enter;
// a result still held there by out_stall delays that hand-off.
// A draw runs the multiply and reduce steps of both generators, then the
// registered table read and the write-back, before the next item is
// accepted; a reseed first adds 8 + SHUFFLE_ENTRIES generator-one steps for
// warmup and table fill. This is set by the single shared multiply-and-reduce
// unit, which registers each product and then reduces it. The table index
// comes from a combinational comparison of the last output with the constant
// slot boundaries. The table reads as all zeros after reset.
module combined_lcg_shuffle_rng_unit #(
	parameter int SHUFFLE_ENTRIES = clsr_pkg::SHUFFLE_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [clsr_pkg::VAL_W-1:0] seed,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [clsr_pkg::VAL_W-1:0] value
);

	localparam int IW = $clog2(SHUFFLE_ENTRIES);
	localparam int CW = $clog2(clsr_pkg::WARMUP_STEPS + SHUFFLE_ENTRIES);
	// width of one table slot in the output range
	localparam logic [31:0] SPAN    = 32'(1 + (2147483562 / SHUFFLE_ENTRIES));
	localparam logic [CW-1:0] SEED_CNT  =
		CW'(clsr_pkg::WARMUP_STEPS + SHUFFLE_ENTRIES - 1);
	localparam logic [CW-1:0] FILL_CNT  = CW'(SHUFFLE_ENTRIES);
	localparam logic [31:0]   WRAP_ADD  = clsr_pkg::MOD_ONE - 32'd1;

	typedef struct packed {
		logic seed_load;  // load both generators from the seed
		logic g1_we;
		logic g2_we;
		logic fill_we;    // table fill during reseed
		logic fill_last;  // last fill step also sets last output
		logic cnt_dec;
		logic idx_load;
		logic tbl_rd;
		logic draw_done;
	} ctl_t;

	clsr_pkg::state_t  state_q, state_d;
	clsr_pkg::mm_req_t mm_req;
	ctl_t              ctl;

	logic [clsr_pkg::VAL_W-1:0] g1_q, g2_q, last_q;
	logic [CW-1:0]              cnt_q;
	logic [IW-1:0]              idx_q;
	logic                       out_valid_q;
	logic [clsr_pkg::VAL_W-1:0] value_q;

	logic [clsr_pkg::VAL_W-1:0] mm_z, mm_res;
	logic [clsr_pkg::VAL_W-1:0] seed_eff;
	logic                       out_free;
	logic                       cnt_zero;
	logic [IW-1:0]              idx_c;
	logic [clsr_pkg::VAL_W-1:0] tbl_rdata;
	logic                       tbl_we;
	logic [IW-1:0]              tbl_waddr;
	logic [clsr_pkg::VAL_W-1:0] tbl_wdata;
	logic [31:0]                diff;
	logic [31:0]                diff_wrap;
	logic [clsr_pkg::VAL_W-1:0] draw_val;

	assign in_stall  = (state_q != clsr_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign cnt_zero  = (cnt_q == '0);
	assign seed_eff  = (seed == '0) ? clsr_pkg::VAL_W'(1) : seed;

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			clsr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = action ? clsr_pkg::ST_SEED_MUL : clsr_pkg::ST_MUL_ONE;
				end
			end
			clsr_pkg::ST_SEED_MUL: state_d = clsr_pkg::ST_SEED_RED;
			clsr_pkg::ST_SEED_RED: begin
				state_d = cnt_zero ? clsr_pkg::ST_MUL_ONE : clsr_pkg::ST_SEED_MUL;
			end
			clsr_pkg::ST_MUL_ONE: state_d = clsr_pkg::ST_RED_ONE;
			clsr_pkg::ST_RED_ONE: state_d = clsr_pkg::ST_RED_TWO;
			clsr_pkg::ST_RED_TWO: state_d = clsr_pkg::ST_READ;
			clsr_pkg::ST_READ: state_d = clsr_pkg::ST_WRITE;
			clsr_pkg::ST_WRITE: begin
				if (out_free) begin
					state_d = clsr_pkg::ST_IDLE;
				end
			end
			default: state_d = clsr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl        = '0;
		mm_req     = '{load: 1'b0, sel: clsr_pkg::GEN_ONE};
		case (state_q)
			clsr_pkg::ST_IDLE: begin
				ctl.seed_load = in_valid && action;
			end
			clsr_pkg::ST_SEED_MUL: begin
				mm_req.load = 1'b1;
			end
			clsr_pkg::ST_SEED_RED: begin
				ctl.g1_we     = 1'b1;
				ctl.fill_we   = (cnt_q < FILL_CNT);
				ctl.fill_last = cnt_zero;
				ctl.cnt_dec   = !cnt_zero;
			end
			clsr_pkg::ST_MUL_ONE: begin
				mm_req.load = 1'b1;
			end
			clsr_pkg::ST_RED_ONE: begin
				// multiplier is free again: start generator two
				ctl.g1_we   = 1'b1;
				mm_req.load = 1'b1;
				mm_req.sel  = clsr_pkg::GEN_TWO;
			end
			clsr_pkg::ST_RED_TWO: begin
				ctl.g2_we    = 1'b1;
				ctl.idx_load = 1'b1;
			end
			clsr_pkg::ST_READ: begin
				ctl.tbl_rd = 1'b1;
			end
			clsr_pkg::ST_WRITE: begin
				ctl.draw_done = out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// ---------------- shared generator step ----------------
	assign mm_z = (mm_req.sel == clsr_pkg::GEN_TWO) ? g2_q : g1_q;

	clsr_modmul u_modmul (
		.clk (clk),
		.req (mm_req),
		.z   (mm_z),
		.res (mm_res)
	);

	// ---------------- table index: last output / SPAN ----------------
	// highest slot whose lower boundary is at or below the last output;
	// the top slot also takes anything past the end of the range
	always_comb begin
		idx_c = '0;
		for (int k = 1; k < SHUFFLE_ENTRIES; k++) begin
			if ({1'b0, last_q} >= SPAN * 32'(k)) begin
				idx_c = IW'(k);
			end
		end
	end

	// ---------------- shuffle table ----------------
	assign tbl_we    = ctl.fill_we || ctl.draw_done;
	assign tbl_waddr = ctl.fill_we ? cnt_q[IW-1:0] : idx_q;
	assign tbl_wdata = ctl.fill_we ? mm_res : g1_q;

	clsr_table #(
		.ENTRIES (SHUFFLE_ENTRIES),
		.IW      (IW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ctl.tbl_rd),
		.rd_addr (idx_q),
		.wr_en   (tbl_we),
		.wr_addr (tbl_waddr),
		.wr_data (tbl_wdata),
		.rd_data (tbl_rdata)
	);

	// entry minus generator two, wrapped into 1 .. MOD_ONE-1
	assign diff      = {1'b0, tbl_rdata} - {1'b0, g2_q};
	assign diff_wrap = diff + WRAP_ADD;
	assign draw_val  = (diff[31] || (diff == '0)) ? diff_wrap[clsr_pkg::VAL_W-1:0]
	                                              : diff[clsr_pkg::VAL_W-1:0];

	// ---------------- state and datapath registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clsr_pkg::ST_IDLE;
			g1_q        <= clsr_pkg::FIRST_RESET;
			g2_q        <= clsr_pkg::SECOND_RESET;
			last_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
		end else begin
			state_q <= state_d;

			if (ctl.seed_load) begin
				g1_q  <= seed_eff;
				g2_q  <= seed_eff;
				cnt_q <= SEED_CNT;
			end
			if (ctl.g1_we) begin
				g1_q <= mm_res;
			end
			if (ctl.g2_we) begin
				g2_q <= mm_res;
			end
			if (ctl.fill_last) begin
				last_q <= mm_res;
			end
			if (ctl.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end

			if (ctl.idx_load) begin
				idx_q <= idx_c;
			end

			if (ctl.draw_done) begin
				last_q      <= draw_val;
				value_q     <= draw_val;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[verif/tb_combined_lcg_shuffle_rng_unit.sv]
module tb_combined_lcg_shuffle_rng_unit;

	localparam int VW      = clsr_pkg::VAL_W;
	localparam int ENTRIES = clsr_pkg::SHUFFLE_ENTRIES_DEF;

	// Schrage split of each modulus: m = a * q + r
	localparam longint QUO_ONE = 53668;
	localparam longint QUO_TWO = 52774;
	localparam longint REM_ONE = 12211;
	localparam longint REM_TWO = 3791;
	localparam longint SPAN    = 1 + (longint'(clsr_pkg::MOD_ONE) - 1) / ENTRIES;

	localparam int RANDOM_ITEMS   = 1880;
	localparam int WATCHDOG_LIMIT = 5000;
	// slowest item is a reseed, which runs the warmup and table fill before its draw
	localparam int TAIL_CYCLES    = 300;

	typedef enum logic {
		ACT_DRAW,
		ACT_RESEED
	} act_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_HOLD,
		STALL_RANDOM
	} stall_mode_t;

	typedef struct {
		act_t          act;
		logic [VW-1:0] seed;
		bit            drain_first;	// wait for every result before sending
	} pending_item_t;

	logic          clk      = 1'b0;
	logic          arst_n   = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic          action   = ACT_DRAW;
	logic [VW-1:0] seed     = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [VW-1:0] value;

	// predictor state
	logic [VW-1:0] gen_one;
	logic [VW-1:0] gen_two;
	logic [VW-1:0] last_draw;
	logic [VW-1:0] shuffle [ENTRIES];

	pending_item_t pending [$];
	pending_item_t item_next;
	logic [VW-1:0] exp_values [$];
	logic [VW-1:0] exp_head;

	int          items_sent   = 0;
	int          results_seen = 0;
	int          error_count  = 0;
	int          burst_left   = 0;
	int          gap_left     = 0;
	int          stall_left   = 0;
	stall_mode_t stall_mode   = STALL_NONE;
	int          idle_cycles  = 0;
	bit          stuck        = 1'b0;

	combined_lcg_shuffle_rng_unit #(
		.SHUFFLE_ENTRIES(ENTRIES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.seed     (seed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value    (value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// reset once, released on a rising edge
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// (a * z) mod m without overflow, Schrage's method
	function automatic logic [VW-1:0] schrage_step(logic [VW-1:0] z, longint mul,
			longint quo, longint rem, longint modulus);
		longint zz;
		longint k;
		longint t;
		zz = longint'(z);
		k  = zz / quo;
		t  = mul * (zz - k * quo) - k * rem;
		if (t < 0)
			t += modulus;
		return t[VW-1:0];
	endfunction

	function automatic logic [VW-1:0] lcg_one_next(logic [VW-1:0] z);
		return schrage_step(z, longint'(clsr_pkg::MUL_ONE), QUO_ONE, REM_ONE,
			longint'(clsr_pkg::MOD_ONE));
	endfunction

	function automatic logic [VW-1:0] lcg_two_next(logic [VW-1:0] z);
		return schrage_step(z, longint'(clsr_pkg::MUL_TWO), QUO_TWO, REM_TWO,
			longint'(clsr_pkg::MOD_TWO));
	endfunction

	function automatic void reset_generators();
		gen_one   = clsr_pkg::FIRST_RESET;
		gen_two   = clsr_pkg::SECOND_RESET;
		last_draw = '0;
		foreach (shuffle[i])
			shuffle[i] = '0;
	endfunction

	// advances the predictor by one item and gives the value it must produce
	function automatic logic [VW-1:0] predict_value(logic act, logic [VW-1:0] seed_in);
		logic [VW-1:0] s;
		longint        idx;
		longint        diff;
		if (act == ACT_RESEED) begin
			s = (seed_in == '0) ? VW'(1) : seed_in;
			gen_one = s;
			gen_two = s;
			repeat (clsr_pkg::WARMUP_STEPS)
				gen_one = lcg_one_next(gen_one);
			// table filled from the top entry down
			for (int i = ENTRIES - 1; i >= 0; i--) begin
				gen_one    = lcg_one_next(gen_one);
				shuffle[i] = gen_one;
			end
			last_draw = shuffle[0];
		end
		gen_one = lcg_one_next(gen_one);
		gen_two = lcg_two_next(gen_two);
		idx = longint'(last_draw) / SPAN;
		if (idx >= ENTRIES)
			idx = ENTRIES - 1;
		diff = longint'(shuffle[idx]) - longint'(gen_two);
		shuffle[idx] = gen_one;
		if (diff < 1)
			diff += longint'(clsr_pkg::MOD_ONE) - 1;
		last_draw = diff[VW-1:0];
		return last_draw;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void add_item(act_t act, logic [VW-1:0] s, bit drain_first = 1'b0);
		pending_item_t it;
		it.act         = act;
		it.seed        = s;
		it.drain_first = drain_first;
		pending.push_back(it);
	endfunction

	function automatic logic [VW-1:0] random_seed();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return VW'(1);
			2:       return '1;
			3:       return clsr_pkg::MOD_ONE[VW-1:0];
			4:       return clsr_pkg::MOD_TWO[VW-1:0];
			5:       return VW'($urandom_range(0, 255));
			default: return VW'($urandom());
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: items in bursts, random gaps, payload held while stalled
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			action     <= ACT_DRAW;
			seed       <= '0;
			burst_left = $urandom_range(1, 12);
			gap_left   = 0;
		end else begin
			if (in_valid && !in_stall) begin
				exp_values.push_back(predict_value(action, seed));
				items_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending.size() == 0 ||
						(pending[0].drain_first && items_sent != results_seen)) begin
					// out of items, or holding off until the block has drained
					in_valid <= 1'b0;
				end else begin
					item_next = pending.pop_front();
					in_valid <= 1'b1;
					action   <= item_next.act;
					seed     <= item_next.seed;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
							: $urandom_range(1, 8);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each accepted result, stalls on its own pattern
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
			stall_mode = STALL_NONE;
		end else begin
			if (out_valid && !out_stall) begin
				if (exp_values.size() == 0) begin
					report_mismatch($sformatf("value %0d with nothing expected", value));
				end else begin
					exp_head = exp_values.pop_front();
					if (value !== exp_head)
						report_mismatch($sformatf("value %0d, expected %0d", value, exp_head));
				end
				results_seen <= results_seen + 1;
			end
			// stretches of free flow, solid stalls and random chatter
			if (stall_left != 0) begin
				stall_left--;
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						stall_mode = STALL_NONE;
						stall_left = $urandom_range(0, 60);
					end
					1: begin
						stall_mode = STALL_HOLD;
						stall_left = $urandom_range(1, 30);
					end
					default: begin
						stall_mode = STALL_RANDOM;
						stall_left = $urandom_range(20, 80);
					end
				endcase
			end
			case (stall_mode)
				STALL_NONE:   out_stall <= 1'b0;
				STALL_HOLD:   out_stall <= 1'b1;
				default:      out_stall <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	// watchdog: no handshake on either side for too long
	always @(posedge clk) begin
		if (arst_n && !stuck) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else if (idle_cycles >= WATCHDOG_LIMIT)
				stuck <= 1'b1;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		reset_generators();

		// draws straight from the reset state; seed bits must be ignored
		add_item(ACT_DRAW, '0);
		add_item(ACT_DRAW, '1);
		add_item(ACT_DRAW, VW'(32'h2AAA_AAAA));
		// zero seed taken as one, then a true seed of one for comparison
		add_item(ACT_RESEED, '0);
		add_item(ACT_DRAW, VW'(32'h5555_5555));
		add_item(ACT_RESEED, VW'(1), 1'b1);
		add_item(ACT_DRAW, '0);
		// largest seed
		add_item(ACT_RESEED, '1);
		add_item(ACT_DRAW, '1);
		add_item(ACT_DRAW, '0);
		// seed equal to the first modulus: generator one collapses to zero
		add_item(ACT_RESEED, clsr_pkg::MOD_ONE[VW-1:0]);
		add_item(ACT_DRAW, '0);
		add_item(ACT_DRAW, '0);
		add_item(ACT_DRAW, '0);
		// seed equal to the second modulus: generator two collapses to zero
		add_item(ACT_RESEED, clsr_pkg::MOD_TWO[VW-1:0]);
		add_item(ACT_DRAW, '0);
		add_item(ACT_DRAW, '0);
		add_item(ACT_DRAW, '0);
		// back-to-back reseeds
		add_item(ACT_RESEED, clsr_pkg::SECOND_RESET);
		add_item(ACT_RESEED, VW'(2));
		add_item(ACT_DRAW, '0);
		add_item(ACT_RESEED, VW'(32'h4000_0000), 1'b1);

		// mostly long draw runs with random seed bits, reseeds sprinkled in
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 99) < 8)
				add_item(ACT_RESEED, random_seed(), ($urandom_range(0, 149) == 0));
			else
				add_item(ACT_DRAW, VW'($urandom()), ($urandom_range(0, 299) == 0));
		end

		while (!stuck && !(pending.size() == 0 && !in_valid && items_sent == results_seen))
			@(posedge clk);
		// let any stray result show up
		if (!stuck)
			repeat (TAIL_CYCLES) @(posedge clk);
		if (exp_values.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", exp_values.size()));

		if (!stuck && error_count == 0)
			$display("combined_lcg_shuffle_rng_unit verification clean");
		else
			$display("combined_lcg_shuffle_rng_unit verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/clsr_pkg.sv
rtl/core/clsr_modmul.sv
rtl/core/clsr_table.sv
rtl/core/combined_lcg_shuffle_rng_unit.sv
verif/tb_combined_lcg_shuffle_rng_unit.sv
